[sv/ccal_pkg.sv]
// shared types and constants of the chroma calibration table match unit
package ccal_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int SUM_W = ((CNT_W > 4) ? CNT_W : 4) + 2;

   localparam int COORD_W = 7;
   localparam int MEAS_W = 6;
   localparam int COEF_W = 32;
   localparam int INDEX_W = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 6;
   localparam int REQ_TDATA_W = 144;
   localparam int RSP_TDATA_W = 120;

   typedef enum logic [2:0] {
      ST_WRITTEN   = 3'd0,
      ST_APPLIED   = 3'd1,
      ST_INVALID   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_UNUSED    = 3'd4
   } status_type;

   typedef struct packed {
      logic                 unused;
      logic [COEF_W-1:0]    blue;
      logic [COEF_W-1:0]    green;
      logic [COEF_W-1:0]    red;
      logic [COORD_W-1:0]   v_high;
      logic [COORD_W-1:0]   v_low;
      logic [COORD_W-1:0]   u_high;
      logic [COORD_W-1:0]   u_low;
   } ccal_entry_type;

   localparam int ENTRY_W = $bits(ccal_entry_type);

endpackage

[sv/ccal_ram.sv]
// generic simple dual port ram with registered read
module ccal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ccal_match.sv]
// area compare unit: checks one table entry against the corrected u and v
module ccal_match (
   input  logic [ccal_pkg::COORD_W-1:0] u,
   input  logic [ccal_pkg::COORD_W-1:0] v,
   input  ccal_pkg::ccal_entry_type     entry,
   output logic                         hit
);
   import ccal_pkg::*;

   logic u_in_range;
   logic v_in_range;

   assign u_in_range = (u >= entry.u_low) && (u <= entry.u_high);
   assign v_in_range = (v >= entry.v_low) && (v <= entry.v_high);
   assign hit = u_in_range && v_in_range;

endmodule

[sv/chroma_calibration_table_match_unit.sv]
// chroma calibration table match unit: table store, offset correction and area search
//
// A write word stores one calibration area and answers in the cycle after it is taken.
// A lookup word whose U and V are both zero (without force calibration) answers just as
// fast with status invalid. Any other lookup corrects U and V, then walks the table one
// entry per cycle through a single range compare unit fed by the registered table read,
// stopping at the first hit. The request side is held low while a lookup is in flight.
// Table entries are undefined until written.
module chroma_calibration_table_match_unit (
   input  logic                               clock,
   input  logic                               reset,
   // entry_index, u_low, u_high, v_low, v_high, red_coef, green_coef, blue_coef,
   // entry_unused, measured_u, measured_v
   input  logic [ccal_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic                               req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // matched_index, red_out, green_out, blue_out, adjusted_u, adjusted_v
   output logic [ccal_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // status
   output logic [2:0]                         rsp_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wen,
   input  logic [ccal_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [ccal_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ccal_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_FINISH
   } state_type;

   localparam logic [CSR_ADDR_W-1:0] REG_ENTRIES   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_PROFILE   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_U_SUB     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_U_AMOUNT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_V_SUB     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_V_AMOUNT  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_FORCE     = 3'd6;

   localparam logic [REQ_TDATA_W-RSP_TDATA_W-1:0] REQ_TYPE_LOOKUP_DUMMY = '0;

   function automatic logic [COORD_W-1:0] apply_offset(
      input logic [MEAS_W-1:0] x,
      input logic              sub,
      input logic [5:0]        amt
   );
      logic [COORD_W-1:0] result;
      if (amt == '0) begin
         result = COORD_W'(x);
      end else if (!sub) begin
         result = COORD_W'(x) + COORD_W'(amt);
      end else if (x < amt) begin
         result = '0;
      end else begin
         result = COORD_W'(x - amt);
      end
      return result;
   endfunction

   // configuration
   logic [5:0]           entries_ff;
   logic [3:0]           profile_ff;
   logic                 u_sub_ff;
   logic [5:0]           u_amount_ff;
   logic                 v_sub_ff;
   logic [5:0]           v_amount_ff;
   logic                 force_ff;

   // request fields
   logic [4:0]           f_entry_index;
   logic [MEAS_W-1:0]    f_measured_u;
   logic [MEAS_W-1:0]    f_measured_v;
   ccal_entry_type       f_entry;

   // sequencer
   state_type            state_ff, state_in;
   logic [COORD_W-1:0]   u_ff, u_in;
   logic [COORD_W-1:0]   v_ff, v_in;
   logic [CNT_W-1:0]     size_ff, size_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 chk_ff, chk_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 miss_ff, miss_in;

   // response word
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [COEF_W-1:0]    rsp_red_ff, rsp_red_in;
   logic [COEF_W-1:0]    rsp_green_ff, rsp_green_in;
   logic [COEF_W-1:0]    rsp_blue_ff, rsp_blue_in;
   logic [COORD_W-1:0]   rsp_u_ff, rsp_u_in;
   logic [COORD_W-1:0]   rsp_v_ff, rsp_v_in;

   // table and compare unit
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;
   ccal_entry_type       rd_entry;
   logic                 hit;

   logic                 slot_free;
   logic                 req_take;
   logic                 issue;
   logic                 uv_invalid;
   logic [COORD_W-1:0]   adj_u;
   logic [COORD_W-1:0]   adj_v;
   logic [CNT_W-1:0]     size_now;
   logic [SUM_W-1:0]     sum_now;

   assign f_entry_index   = req_tdata[4:0];
   assign f_entry.u_low   = req_tdata[11:5];
   assign f_entry.u_high  = req_tdata[18:12];
   assign f_entry.v_low   = req_tdata[25:19];
   assign f_entry.v_high  = req_tdata[32:26];
   assign f_entry.red     = req_tdata[64:33];
   assign f_entry.green   = req_tdata[96:65];
   assign f_entry.blue    = req_tdata[128:97];
   assign f_entry.unused  = req_tdata[129];
   assign f_measured_u    = req_tdata[135:130];
   assign f_measured_v    = req_tdata[141:136];

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign req_take   = req_tvalid && req_tready;

   assign adj_u      = apply_offset(f_measured_u, u_sub_ff, u_amount_ff);
   assign adj_v      = apply_offset(f_measured_v, v_sub_ff, v_amount_ff);
   assign uv_invalid = (f_measured_u == '0) && (f_measured_v == '0) && !force_ff;
   assign size_now   = (int'(entries_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(entries_ff);

   assign issue   = (cnt_ff < size_ff);
   assign sum_now = SUM_W'(pos_ff) + SUM_W'(profile_ff);

   assign ram_wr_en   = req_take && !req_tuser && (int'(f_entry_index) < TABLE_DEPTH);
   assign ram_wr_addr = IDX_W'(f_entry_index);
   assign rd_entry    = ccal_entry_type'(ram_rd_data);

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_ff[IDX_W-1:0];
      case (state_ff)
         S_SCAN: begin
            ram_rd_en   = issue;
            ram_rd_addr = cnt_ff[IDX_W-1:0];
         end
         S_RESOLVE: begin
            ram_rd_en   = (sum_now < SUM_W'(size_ff));
            ram_rd_addr = sum_now[IDX_W-1:0];
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   ccal_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (f_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ccal_match u_match (
      .u     (u_ff),
      .v     (v_ff),
      .entry (rd_entry),
      .hit   (hit)
   );

   always_comb begin
      state_in      = state_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      size_in       = size_ff;
      cnt_in        = cnt_ff;
      chk_in        = 1'b0;
      pos_in        = pos_ff;
      sum_in        = sum_ff;
      miss_in       = miss_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_u_in      = rsp_u_ff;
      rsp_v_in      = rsp_v_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (!req_tuser || uv_invalid) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = req_tuser ? ST_INVALID : ST_WRITTEN;
                  rsp_index_in  = '0;
                  rsp_red_in    = '0;
                  rsp_green_in  = '0;
                  rsp_blue_in   = '0;
                  rsp_u_in      = '0;
                  rsp_v_in      = '0;
               end else begin
                  u_in     = adj_u;
                  v_in     = adj_v;
                  size_in  = size_now;
                  cnt_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            chk_in = issue;
            if (issue) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (chk_ff && hit) begin
               pos_in   = cnt_ff - 1'b1;
               state_in = S_RESOLVE;
            end else if (!issue) begin
               pos_in   = cnt_ff;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            sum_in   = sum_now;
            miss_in  = (sum_now >= SUM_W'(size_ff));
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = sum_ff[INDEX_W-1:0];
               rsp_u_in     = u_ff;
               rsp_v_in     = v_ff;
               rsp_red_in   = '0;
               rsp_green_in = '0;
               rsp_blue_in  = '0;
               if (miss_ff) begin
                  rsp_status_in = ST_NOT_FOUND;
               end else if (rd_entry.unused) begin
                  rsp_status_in = ST_UNUSED;
               end else begin
                  rsp_status_in = ST_APPLIED;
                  rsp_red_in    = rd_entry.red;
                  rsp_green_in  = rd_entry.green;
                  rsp_blue_in   = rd_entry.blue;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= '0;
         profile_ff   <= '0;
         u_sub_ff     <= 1'b0;
         u_amount_ff  <= '0;
         v_sub_ff     <= 1'b0;
         v_amount_ff  <= '0;
         force_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_addr)
               REG_ENTRIES:  entries_ff  <= csr_wdata;
               REG_PROFILE:  profile_ff  <= csr_wdata[3:0];
               REG_U_SUB:    u_sub_ff    <= csr_wdata[0];
               REG_U_AMOUNT: u_amount_ff <= csr_wdata;
               REG_V_SUB:    v_sub_ff    <= csr_wdata[0];
               REG_V_AMOUNT: v_amount_ff <= csr_wdata;
               REG_FORCE:    force_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      u_ff          <= u_in;
      v_ff          <= v_in;
      size_ff       <= size_in;
      cnt_ff        <= cnt_in;
      pos_ff        <= pos_in;
      sum_ff        <= sum_in;
      miss_ff       <= miss_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_u_ff      <= rsp_u_in;
      rsp_v_ff      <= rsp_v_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {REQ_TYPE_LOOKUP_DUMMY[RSP_TDATA_W-117:0], rsp_v_ff, rsp_u_ff,
                        rsp_blue_ff, rsp_green_ff, rsp_red_ff, rsp_index_ff};

`ifndef SYNTH
   // table is only written between lookups
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_IDLE))
      else $error("table write during lookup");

   // scan never reads past the clipped table size
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && ram_rd_en) |-> (cnt_ff < size_ff) && (int'(size_ff) <= TABLE_DEPTH))
      else $error("scan read beyond table size");

   // a checked entry always follows an issued read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_ff) |-> (cnt_ff != '0))
      else $error("check without an issued read");

   // a resolved index inside the table reads that entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !miss_ff) |-> (sum_ff < SUM_W'(size_ff)))
      else $error("applied index outside the table");

   // no word is taken while a lookup is in flight
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("request taken during lookup");
`endif

endmodule

[tb/chroma_calibration_table_match_unit_test.sv]
// testbench of the chroma calibration table match unit: directed and random words
`timescale 1ns / 100ps

module chroma_calibration_table_match_unit_test;
   import ccal_pkg::*;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      REG_ENTRIES_IN_USE = 3'd0,
      REG_PROFILE_OFFSET = 3'd1,
      REG_U_SUBTRACT     = 3'd2,
      REG_U_AMOUNT       = 3'd3,
      REG_V_SUBTRACT     = 3'd4,
      REG_V_AMOUNT       = 3'd5,
      REG_FORCE_CAL      = 3'd6
   } csr_reg_type;

   typedef struct {
      logic        kind;
      logic [4:0]  slot;
      logic [6:0]  u_low, u_high, v_low, v_high;
      logic [31:0] red, green, blue;
      logic        unused;
      logic [5:0]  meas_u, meas_v;
   } chroma_word_type;

   typedef struct {
      status_type  status;
      logic [5:0]  index;
      logic [31:0] red, green, blue;
      logic [6:0]  adj_u, adj_v;
   } match_outcome_type;

   typedef struct {
      int unsigned entries, profile, u_sub, u_amt, v_sub, v_amt, force_cal;
   } settings_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   ccal_entry_type     area_shadow [TABLE_DEPTH];
   settings_type       active_cfg = '{0, 0, 0, 0, 0, 0, 0};
   match_outcome_type  outcome_queue [$];
   int unsigned        errors = 0;
   bit                 idle_on = 1'b1;
   int unsigned        rsp_hold_cycles = 0;

   chroma_calibration_table_match_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned shifted_coord(int unsigned x, int unsigned sub,
                                                 int unsigned amt);
      if (amt == 0) return x;
      if (sub == 0) return x + amt;
      return (x < amt) ? 0 : x - amt;
   endfunction

   // updates the shadow table on a write word and predicts the response of every word
   function automatic match_outcome_type match_outcome(chroma_word_type w);
      match_outcome_type o;
      int unsigned u, v, size, k;
      o.status = ST_WRITTEN;
      o.index = '0;
      o.red = '0;
      o.green = '0;
      o.blue = '0;
      o.adj_u = '0;
      o.adj_v = '0;
      if (w.kind == REQ_WRITE) begin
         area_shadow[w.slot] = '{unused: w.unused, blue: w.blue, green: w.green, red: w.red,
                                 v_high: w.v_high, v_low: w.v_low, u_high: w.u_high,
                                 u_low: w.u_low};
         return o;
      end
      if (w.meas_u == 0 && w.meas_v == 0 && active_cfg.force_cal == 0) begin
         o.status = ST_INVALID;
         return o;
      end
      u = shifted_coord(w.meas_u, active_cfg.u_sub, active_cfg.u_amt) & 32'h7f;
      v = shifted_coord(w.meas_v, active_cfg.v_sub, active_cfg.v_amt) & 32'h7f;
      o.adj_u = u[6:0];
      o.adj_v = v[6:0];
      size = (active_cfg.entries > TABLE_DEPTH) ? TABLE_DEPTH : active_cfg.entries;
      for (k = 0; k < size; k++) begin
         if (u >= area_shadow[k].u_low && u <= area_shadow[k].u_high &&
             v >= area_shadow[k].v_low && v <= area_shadow[k].v_high) break;
      end
      k += active_cfg.profile;
      o.index = k[5:0];
      if (k >= size) begin
         o.status = ST_NOT_FOUND;
      end else if (area_shadow[k].unused) begin
         o.status = ST_UNUSED;
      end else begin
         o.status = ST_APPLIED;
         o.red = area_shadow[k].red;
         o.green = area_shadow[k].green;
         o.blue = area_shadow[k].blue;
      end
      return o;
   endfunction

   function automatic chroma_word_type random_lookup();
      chroma_word_type w;
      w.kind = REQ_LOOKUP;
      w.slot = 5'($urandom);
      w.u_low = 7'($urandom);
      w.u_high = 7'($urandom);
      w.v_low = 7'($urandom);
      w.v_high = 7'($urandom);
      w.red = $urandom;
      w.green = $urandom;
      w.blue = $urandom;
      w.unused = 1'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         w.meas_u = '0;
         w.meas_v = '0;
      end else begin
         w.meas_u = 6'($urandom_range(0, 63));
         w.meas_v = 6'($urandom_range(0, 63));
      end
      return w;
   endfunction

   function automatic chroma_word_type random_area(logic [4:0] slot);
      chroma_word_type w;
      int unsigned span;
      w = random_lookup();
      w.kind = REQ_WRITE;
      w.slot = slot;
      w.unused = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
         0: begin
            w.u_low = 7'd0;
            w.u_high = 7'd127;
            w.v_low = 7'd0;
            w.v_high = 7'd127;
         end
         1: begin
            // inverted ranges never hit
            w.u_low = 7'($urandom_range(64, 127));
            w.u_high = 7'($urandom_range(0, 63));
            w.v_low = 7'($urandom_range(0, 127));
            w.v_high = 7'($urandom_range(0, 127));
         end
         default: begin
            w.u_low = 7'($urandom_range(0, 90));
            span = w.u_low + $urandom_range(0, 50);
            w.u_high = (span > 127) ? 7'd127 : span[6:0];
            w.v_low = 7'($urandom_range(0, 90));
            span = w.v_low + $urandom_range(0, 50);
            w.v_high = (span > 127) ? 7'd127 : span[6:0];
         end
      endcase
      return w;
   endfunction

   function automatic chroma_word_type lookup_at(int unsigned u, int unsigned v);
      chroma_word_type w;
      w = random_lookup();
      w.meas_u = u[5:0];
      w.meas_v = v[5:0];
      return w;
   endfunction

   function automatic settings_type random_settings();
      settings_type s;
      case ($urandom_range(0, 9))
         0: s.entries = 0;
         1: s.entries = $urandom_range(33, 63);
         2: s.entries = 32;
         default: s.entries = $urandom_range(1, 32);
      endcase
      s.profile = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
      s.u_sub = $urandom_range(0, 1);
      s.u_amt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 63);
      s.v_sub = $urandom_range(0, 1);
      s.v_amt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 63);
      s.force_cal = $urandom_range(0, 1);
      return s;
   endfunction

   task automatic send_word(chroma_word_type w);
      int unsigned gap;
      req_tdata <= {2'b00, w.meas_v, w.meas_u, w.unused, w.blue, w.green, w.red,
                    w.v_high, w.v_low, w.u_high, w.u_low, w.slot};
      req_tuser <= w.kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      outcome_queue.push_back(match_outcome(w));
      gap = idle_cycles();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (outcome_queue.size() != 0) @(posedge clock);
   endtask

   task automatic csr_word(csr_reg_type idx, int unsigned value);
      csr_wen <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic program_settings(settings_type s);
      drain();
      csr_word(REG_ENTRIES_IN_USE, s.entries);
      csr_word(REG_PROFILE_OFFSET, s.profile);
      csr_word(REG_U_SUBTRACT, s.u_sub);
      csr_word(REG_U_AMOUNT, s.u_amt);
      csr_word(REG_V_SUBTRACT, s.v_sub);
      csr_word(REG_V_AMOUNT, s.v_amt);
      csr_word(REG_FORCE_CAL, s.force_cal);
      csr_wen <= 1'b0;
      active_cfg = '{s.entries & 63, s.profile & 15, s.u_sub & 1, s.u_amt & 63,
                     s.v_sub & 1, s.v_amt & 63, s.force_cal & 1};
   endtask

   // register defaults, empty table: nothing is read from it
   task automatic test_reset_defaults();
      send_word(lookup_at(0, 0));
      send_word(lookup_at(63, 63));
      send_word(lookup_at(1, 0));
   endtask

   task automatic test_fill_table();
      chroma_word_type w;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         w = random_area(s[4:0]);
         case (s)
            0: begin
               w.u_low = 7'd10; w.u_high = 7'd20; w.v_low = 7'd30; w.v_high = 7'd40;
               w.red = '1; w.green = '1; w.blue = '1; w.unused = 1'b0;
            end
            1: begin
               w.u_low = 7'd0; w.u_high = 7'd0; w.v_low = 7'd0; w.v_high = 7'd0;
               w.red = '0; w.green = '0; w.blue = '0; w.unused = 1'b0;
            end
            2: begin
               w.u_low = 7'd127; w.u_high = 7'd127; w.v_low = 7'd127; w.v_high = 7'd127;
            end
            3: begin
               w.u_low = 7'd0; w.u_high = 7'd127; w.v_low = 7'd0; w.v_high = 7'd127;
               w.unused = 1'b1;
            end
            31: begin
               w.u_low = 7'd0; w.u_high = 7'd127; w.v_low = 7'd0; w.v_high = 7'd127;
               w.unused = 1'b0;
            end
            default: ;
         endcase
         send_word(w);
      end
   endtask

   task automatic test_directed_lookups();
      program_settings('{32, 0, 0, 0, 0, 0, 0});
      send_word(lookup_at(15, 35));
      send_word(lookup_at(0, 0));
      send_word(lookup_at(63, 63));
      send_word(lookup_at(20, 40));
      program_settings('{32, 0, 0, 0, 0, 0, 1});
      send_word(lookup_at(0, 0));
      send_word(lookup_at(10, 30));
      // subtract to the floor on U, add the largest amount on V, table size clipped
      program_settings('{63, 15, 1, 63, 0, 63, 1});
      send_word(lookup_at(0, 0));
      send_word(lookup_at(63, 0));
      send_word(lookup_at(5, 63));
      program_settings('{0, 15, 0, 0, 1, 63, 0});
      send_word(lookup_at(20, 20));
      send_word(lookup_at(0, 0));
      program_settings('{1, 0, 0, 5, 1, 0, 0});
      send_word(lookup_at(10, 35));
      send_word(lookup_at(40, 40));
      program_settings('{33, 1, 1, 1, 1, 1, 0});
      send_word(lookup_at(12, 32));
      send_word(lookup_at(63, 63));
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 12; phase++) begin
         program_settings(random_settings());
         idle_on = (phase % 3 != 2);
         for (int n = 0; n < 140; n++) begin
            if ($urandom_range(0, 3) == 0) send_word(random_area(5'($urandom_range(0, 31))));
            else send_word(random_lookup());
         end
      end
      idle_on = 1'b1;
   endtask

   // result side held off long enough that the unit stops taking words
   task automatic test_backpressure();
      program_settings('{32, 0, 0, 0, 0, 0, 1});
      idle_on = 1'b0;
      rsp_hold_cycles = 400;
      for (int n = 0; n < 30; n++) begin
         if (n % 5 == 0) send_word(random_area(5'($urandom_range(0, 31))));
         else send_word(random_lookup());
      end
      idle_on = 1'b1;
   endtask

   initial begin : rsp_ready_driver
      int unsigned stall;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? idle_cycles() : 0;
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic note_error(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : rsp_check
      match_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_queue.size() == 0) begin
            note_error($sformatf("unexpected word: status %0d data %h", rsp_tuser, rsp_tdata));
         end else begin
            want = outcome_queue.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[5:0] !== want.index ||
                rsp_tdata[37:6] !== want.red || rsp_tdata[69:38] !== want.green ||
                rsp_tdata[101:70] !== want.blue || rsp_tdata[108:102] !== want.adj_u ||
                rsp_tdata[115:109] !== want.adj_v)
               note_error($sformatf({"mismatch: expected status %0d idx %0d rgb %h %h %h",
                                     " uv %0d %0d, got status %0d idx %0d rgb %h %h %h",
                                     " uv %0d %0d"},
                                    want.status, want.index, want.red, want.green, want.blue,
                                    want.adj_u, want.adj_v, rsp_tuser, rsp_tdata[5:0],
                                    rsp_tdata[37:6], rsp_tdata[69:38], rsp_tdata[101:70],
                                    rsp_tdata[108:102], rsp_tdata[115:109]));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_fill_table();
      test_directed_lookups();
      test_random_traffic();
      test_backpressure();
      drain();
      repeat (60) @(posedge clock);
      errors += outcome_queue.size();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[files.f]
sv/ccal_pkg.sv
sv/ccal_ram.sv
sv/ccal_match.sv
sv/chroma_calibration_table_match_unit.sv
tb/chroma_calibration_table_match_unit_test.sv
